// ----- design/twd_pkg.sv -----
// ----------------------------------------------------------------------------
// twd_pkg
// Shared types and codes for the task/worker dispatcher.
// ----------------------------------------------------------------------------
package twd_pkg;

    // event kinds
    localparam logic [1:0] FUNC_TASK  = 2'd0;
    localparam logic [1:0] FUNC_READY = 2'd1;
    localparam logic [1:0] FUNC_DONE  = 2'd2;

    localparam logic [10:0] CAP_RESET = 11'd1024;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] task_id;
        logic [47:0] created_time;
        logic [47:0] now_time;
        logic [5:0]  worker_idx;
    } t_item;

    typedef struct packed {
        logic        dispatch_valid;
        logic [5:0]  dispatch_worker;
        logic [31:0] dispatch_task_id;
        logic [47:0] dispatch_created;
        logic        task_dropped;
        logic        worker_lost;
        logic [10:0] queue_fill;
        logic [6:0]  idle_workers;
        logic [31:0] processed_count;
        logic [31:0] dropped_count;
        logic [63:0] latency_total;
    } t_result;

    // one task queue entry
    typedef struct packed {
        logic [31:0] task_id;
        logic [47:0] created_time;
    } t_task;

    typedef struct packed {
        logic push;
        logic pop;
    } t_fifo_ctl;

endpackage

// ----- design/twd_fifo.sv -----
// ----------------------------------------------------------------------------
// twd_fifo
// Memory-based fifo with a prefetched head register; the head is valid
// whenever the count is nonzero, including right after a push into empty.
// ----------------------------------------------------------------------------
module twd_fifo #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  twd_pkg::t_fifo_ctl             i_ctl,
    input  logic [WIDTH-1:0]               i_push_data,
    output logic [WIDTH-1:0]               o_head,
    output logic [$clog2(DEPTH+1)-1:0]     o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic [WIDTH-1:0] r_mem_q;
    logic [WIDTH-1:0] r_byp_data;
    logic             r_byp, n_byp;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_ctl.push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
        end
        if (i_ctl.pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);
        end
        n_count = r_count + CW'(i_ctl.push) - CW'(i_ctl.pop);
        // a write landing on the next head slot is forwarded
        n_byp   = i_ctl.push && (r_wr_ptr == n_rd_ptr);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
        r_mem_q    <= r_mem[n_rd_ptr];
        r_byp_data <= i_push_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
            r_byp    <= 1'b0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
            r_byp    <= n_byp;
        end
    end

    assign o_head  = r_byp ? r_byp_data : r_mem_q;
    assign o_count = r_count;

endmodule

// ----- design/twd_core.sv -----
// ----------------------------------------------------------------------------
// twd_core
// Decode, dispatch pairing and running totals, one event per cycle of i_fire.
// ----------------------------------------------------------------------------
module twd_core #(
    parameter int TASK_DEPTH   = 1024,
    parameter int WORKER_DEPTH = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_fire,
    input  twd_pkg::t_item                      i_item,
    input  logic [63:0]                         i_lat_delta,
    input  logic [10:0]                         i_cap,
    input  logic [$clog2(TASK_DEPTH+1)-1:0]     i_task_count,
    input  twd_pkg::t_task                      i_task_head,
    input  logic [$clog2(WORKER_DEPTH+1)-1:0]   i_idle_count,
    input  logic [5:0]                          i_idle_head,
    output twd_pkg::t_fifo_ctl                  o_task_ctl,
    output twd_pkg::t_fifo_ctl                  o_idle_ctl,
    output twd_pkg::t_result                    o_result
);

    localparam int TCW  = $clog2(TASK_DEPTH + 1);
    localparam int WCW  = $clog2(WORKER_DEPTH + 1);
    localparam int CMPW = (TCW > 11) ? TCW : 11;

    logic [CMPW-1:0] cap_ext, depth_ext, cap_eff;
    logic            is_task, is_worker, is_done;
    logic            task_full, idle_full;
    logic            task_in, idle_in, disp_task, disp_worker;
    logic [TCW-1:0]  n_task_count;
    logic [WCW-1:0]  n_idle_count;
    logic [31:0]     r_processed, n_processed;
    logic [31:0]     r_dropped, n_dropped;
    logic [63:0]     r_latency, n_latency;

    always_comb begin
        cap_ext   = CMPW'(i_cap);
        depth_ext = CMPW'(TASK_DEPTH);
        cap_eff   = (cap_ext > depth_ext) ? depth_ext : cap_ext;

        is_task   = (i_item.func == twd_pkg::FUNC_TASK);
        is_done   = (i_item.func == twd_pkg::FUNC_DONE);
        is_worker = (i_item.func == twd_pkg::FUNC_READY) || is_done;

        task_full = CMPW'(i_task_count) >= cap_eff;
        idle_full = i_idle_count >= WCW'(WORKER_DEPTH);
        task_in   = is_task && !task_full;
        idle_in   = is_worker && !idle_full;

        // at most one queue is nonempty between events, so a dispatch
        // always involves the item that arrives now
        disp_task   = task_in && (i_idle_count != '0);
        disp_worker = idle_in && (i_task_count != '0);

        o_task_ctl.push = i_fire && task_in && !disp_task;
        o_task_ctl.pop  = i_fire && disp_worker;
        o_idle_ctl.push = i_fire && idle_in && !disp_worker;
        o_idle_ctl.pop  = i_fire && disp_task;

        n_task_count = i_task_count + TCW'(task_in && !disp_task) - TCW'(disp_worker);
        n_idle_count = i_idle_count + WCW'(idle_in && !disp_worker) - WCW'(disp_task);

        n_processed = r_processed + 32'(is_done);
        n_dropped   = r_dropped + 32'(is_task && task_full);
        n_latency   = is_done ? (r_latency + i_lat_delta) : r_latency;

        o_result                  = '0;
        o_result.dispatch_valid   = disp_task || disp_worker;
        if (disp_task) begin
            o_result.dispatch_worker  = i_idle_head;
            o_result.dispatch_task_id = i_item.task_id;
            o_result.dispatch_created = i_item.created_time;
        end else if (disp_worker) begin
            o_result.dispatch_worker  = i_item.worker_idx;
            o_result.dispatch_task_id = i_task_head.task_id;
            o_result.dispatch_created = i_task_head.created_time;
        end
        o_result.task_dropped    = is_task && task_full;
        o_result.worker_lost     = is_worker && idle_full;
        o_result.queue_fill      = 11'(n_task_count);
        o_result.idle_workers    = 7'(n_idle_count);
        o_result.processed_count = n_processed;
        o_result.dropped_count   = n_dropped;
        o_result.latency_total   = n_latency;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_processed <= '0;
            r_dropped   <= '0;
            r_latency   <= '0;
        end else if (i_fire) begin
            r_processed <= n_processed;
            r_dropped   <= n_dropped;
            r_latency   <= n_latency;
        end
    end

endmodule

// ----- design/task_worker_dispatcher.sv -----
// ----------------------------------------------------------------------------
// task_worker_dispatcher
// Pairs queued tasks with idle workers and keeps drop, processed and
// latency totals.
// ----------------------------------------------------------------------------
// Usage: events enter on i_in_valid/i_in_data and a transfer happens when
// i_in_valid is high and o_in_stall is low. Each event (task arrival, worker
// ready, worker done) yields exactly one result on o_out_valid/o_out_data,
// taken when i_out_stall is low.
// An event is held in the input register, then the decode and pairing logic
// writes the result register. Throughput is one event per cycle unless the
// receiver stalls; the task and idle-worker queues each have one memory
// write port and one read port feeding a prefetched head register, so one
// push and one pop per queue fit in every cycle.
// The capacity register is to be written by the user with i_cfg_we/i_cfg_wdata
// only while no event is in flight; the block does not enforce this. It
// resets to 1024. Reset empties both queues and clears all totals; no
// clearing pass is needed. While the receiver stalls, the result register
// holds; one more event may wait in the input register, then o_in_stall rises.
// ----------------------------------------------------------------------------
module task_worker_dispatcher #(
    parameter int TASK_DEPTH   = 1024,
    parameter int WORKER_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  twd_pkg::t_item    i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output twd_pkg::t_result  o_out_data,
    input  logic              i_cfg_we,
    input  logic [10:0]       i_cfg_wdata
);

    localparam int TCW = $clog2(TASK_DEPTH + 1);
    localparam int WCW = $clog2(WORKER_DEPTH + 1);

    twd_pkg::t_item     r_in;
    logic               r_in_valid;
    logic [63:0]        r_lat_delta;
    twd_pkg::t_result   r_out;
    logic               r_out_valid;
    logic [10:0]        r_cap;

    logic               fire, accept;
    twd_pkg::t_result   result;
    twd_pkg::t_fifo_ctl task_ctl, idle_ctl;
    twd_pkg::t_task     task_push, task_head;
    logic [TCW-1:0]     task_count;
    logic [WCW-1:0]     idle_count;
    logic [5:0]         idle_head;

    assign fire       = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !fire;
    assign accept     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in        <= i_in_data;
            r_lat_delta <= 64'(i_in_data.now_time) - 64'(i_in_data.created_time);
        end
        if (fire) begin
            r_out <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= twd_pkg::CAP_RESET;
        end else begin
            if (accept) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
        end
    end

    always_comb begin
        task_push.task_id      = r_in.task_id;
        task_push.created_time = r_in.created_time;
    end

    twd_fifo #(
        .WIDTH ($bits(twd_pkg::t_task)),
        .DEPTH (TASK_DEPTH)
    ) u_task_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (task_ctl),
        .i_push_data (task_push),
        .o_head      (task_head),
        .o_count     (task_count)
    );

    twd_fifo #(
        .WIDTH (6),
        .DEPTH (WORKER_DEPTH)
    ) u_idle_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (idle_ctl),
        .i_push_data (r_in.worker_idx),
        .o_head      (idle_head),
        .o_count     (idle_count)
    );

    twd_core #(
        .TASK_DEPTH   (TASK_DEPTH),
        .WORKER_DEPTH (WORKER_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_item       (r_in),
        .i_lat_delta  (r_lat_delta),
        .i_cap        (r_cap),
        .i_task_count (task_count),
        .i_task_head  (task_head),
        .i_idle_count (idle_count),
        .i_idle_head  (idle_head),
        .o_task_ctl   (task_ctl),
        .o_idle_ctl   (idle_ctl),
        .o_result     (result)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // pairing leaves at most one queue holding entries
    a_one_queue_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((task_count != '0) && (idle_count != '0)))
        else $error("tasks and idle workers wait at the same time");

    a_task_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        task_count <= TCW'(TASK_DEPTH))
        else $error("task queue count above depth");

    a_drop_no_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.task_dropped) |-> !o_out_data.dispatch_valid)
        else $error("dropped task reported together with a dispatch");

    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> o_out_valid)
        else $error("processed event produced no result");

endmodule

// ----- dv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for task_worker_dispatcher: a queue-based model of the
// task and idle-worker FIFOs predicts every status word, and a monitor checks
// each output transfer field by field under random gaps, stalls and
// capacity settings.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int TASK_DEPTH    = 1024;
    localparam int WORKER_DEPTH  = 64;
    localparam int STUCK_LIMIT   = 2000;
    localparam int PRESSURE_HOLD = 150;
    localparam int RANDOM_ITEMS  = 1760;
    localparam int PHASES        = 8;
    localparam int REPORT_CAP    = 200;

    // event kind the block does not decode
    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    twd_pkg::t_item   in_data   = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    twd_pkg::t_result out_data;
    logic             cfg_we    = 1'b0;
    logic [10:0]      cfg_wdata = '0;

    always #5 clk = ~clk;

    task_worker_dispatcher #(
        .TASK_DEPTH   (TASK_DEPTH),
        .WORKER_DEPTH (WORKER_DEPTH)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    // dispatcher model state
    twd_pkg::t_task   pending_tasks[$];
    logic [5:0]       idle_pool[$];
    logic [10:0]      capacity_reg    = twd_pkg::CAP_RESET;
    logic [31:0]      processed_total = '0;
    logic [31:0]      dropped_total   = '0;
    logic [63:0]      latency_sum     = '0;
    twd_pkg::t_result status_due[$];

    int events_sent     = 0;
    int results_checked = 0;
    int error_count     = 0;
    int drops_seen      = 0;
    int losses_seen     = 0;
    bit calm            = 1'b0;
    int hold_req        = 0;

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic twd_pkg::t_item make_event(logic [1:0] func, logic [31:0] tid,
                                                  logic [47:0] created, logic [47:0] now,
                                                  logic [5:0] wid);
        twd_pkg::t_item ev;
        ev.func         = func;
        ev.task_id      = tid;
        ev.created_time = created;
        ev.now_time     = now;
        ev.worker_idx   = wid;
        return ev;
    endfunction

    function automatic twd_pkg::t_item random_event(int arrival_pct);
        twd_pkg::t_item ev;
        int             r;
        r               = $urandom_range(0, 99);
        ev.task_id      = $urandom();
        ev.created_time = 48'({$urandom(), $urandom()});
        ev.now_time     = 48'({$urandom(), $urandom()});
        ev.worker_idx   = 6'($urandom());
        if (r < arrival_pct) begin
            ev.func = twd_pkg::FUNC_TASK;
        end else if (r >= 96) begin
            ev.func = FUNC_UNKNOWN;
        end else if (r < arrival_pct + (96 - arrival_pct) / 2) begin
            ev.func = twd_pkg::FUNC_READY;
        end else begin
            ev.func = twd_pkg::FUNC_DONE;
            // mostly plausible latencies, sometimes anything at all
            if ($urandom_range(0, 4) != 0)
                ev.now_time = ev.created_time + 48'($urandom_range(0, 60000));
        end
        return ev;
    endfunction

    task automatic predict_status(input twd_pkg::t_item ev);
        twd_pkg::t_result st;
        twd_pkg::t_task   head;
        int               limit;
        st    = '0;
        limit = (int'(capacity_reg) < TASK_DEPTH) ? int'(capacity_reg) : TASK_DEPTH;
        if (ev.func == twd_pkg::FUNC_TASK) begin
            if (pending_tasks.size() >= limit) begin
                st.task_dropped = 1'b1;
                dropped_total++;
                drops_seen++;
            end else begin
                head.task_id      = ev.task_id;
                head.created_time = ev.created_time;
                pending_tasks.push_back(head);
            end
        end
        if (ev.func == twd_pkg::FUNC_DONE) begin
            processed_total++;
            latency_sum += 64'(ev.now_time) - 64'(ev.created_time);
        end
        if (ev.func == twd_pkg::FUNC_READY || ev.func == twd_pkg::FUNC_DONE) begin
            if (idle_pool.size() >= WORKER_DEPTH) begin
                st.worker_lost = 1'b1;
                losses_seen++;
            end else begin
                idle_pool.push_back(ev.worker_idx);
            end
        end
        // pairing runs after every event, unknown kinds included
        if (pending_tasks.size() > 0 && idle_pool.size() > 0) begin
            head                = pending_tasks.pop_front();
            st.dispatch_valid   = 1'b1;
            st.dispatch_worker  = idle_pool.pop_front();
            st.dispatch_task_id = head.task_id;
            st.dispatch_created = head.created_time;
        end
        st.queue_fill      = 11'(pending_tasks.size());
        st.idle_workers    = 7'(idle_pool.size());
        st.processed_count = processed_total;
        st.dropped_count   = dropped_total;
        st.latency_total   = latency_sum;
        status_due.push_back(st);
    endtask

    task automatic post_event(input twd_pkg::t_item ev);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= ev;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_status(ev);
        events_sent++;
    endtask

    // wait until every posted event has produced its status
    task automatic settle();
        in_valid <= 1'b0;
        while (status_due.size() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [10:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we       <= 1'b0;
        capacity_reg = value;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (got !== want) begin
            if (error_count < REPORT_CAP)
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin
        twd_pkg::t_result want;
        if (rst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
            if (status_due.size() == 0) begin
                $error("status transfer with no event outstanding");
                error_count++;
            end else begin
                want = status_due.pop_front();
                results_checked++;
                compare_field("dispatch_valid", want.dispatch_valid, out_data.dispatch_valid);
                compare_field("dispatch_worker", want.dispatch_worker,
                              out_data.dispatch_worker);
                compare_field("dispatch_task_id", want.dispatch_task_id,
                              out_data.dispatch_task_id);
                compare_field("dispatch_created", want.dispatch_created,
                              out_data.dispatch_created);
                compare_field("task_dropped", want.task_dropped, out_data.task_dropped);
                compare_field("worker_lost", want.worker_lost, out_data.worker_lost);
                compare_field("queue_fill", want.queue_fill, out_data.queue_fill);
                compare_field("idle_workers", want.idle_workers, out_data.idle_workers);
                compare_field("processed_count", want.processed_count,
                              out_data.processed_count);
                compare_field("dropped_count", want.dropped_count, out_data.dropped_count);
                compare_field("latency_total", want.latency_total, out_data.latency_total);
            end
        end
    end

    // receiver: random stalls, or one long hold-off when requested
    initial begin
        int stall_left;
        int held;
        stall_left = 0;
        forever begin
            @(posedge clk);
            if (hold_req > 0) begin
                out_stall <= 1'b1;
                held      = hold_req;
                hold_req  = 0;
                repeat (held - 1) @(posedge clk);
            end else if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end else begin
                out_stall <= 1'b0;
                if (!calm && $urandom_range(0, 3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
                stuck = 0;
            else
                stuck++;
        end
        $display("task_worker_dispatcher verification failed");
        $finish;
    end

    task automatic test_directed_events();
        post_event(make_event(FUNC_UNKNOWN, '1, '1, '1, '1));
        post_event(make_event(twd_pkg::FUNC_READY, '1, '1, '1, 6'd0));
        post_event(make_event(twd_pkg::FUNC_READY, '0, '0, '0, 6'd63));
        post_event(make_event(twd_pkg::FUNC_TASK, '0, '0, '1, 6'd63));
        post_event(make_event(twd_pkg::FUNC_TASK, '1, '1, '0, 6'd0));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd12345, 48'd1000, '0, 6'd9));
        // done with now below created wraps the latency
        post_event(make_event(twd_pkg::FUNC_DONE, '0, '1, '0, 6'd5));
        post_event(make_event(twd_pkg::FUNC_DONE, '1, '0, '1, 6'd6));
        post_event(make_event(twd_pkg::FUNC_DONE, 32'd7, 48'd777, 48'd777, 6'd7));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'hA5A5_5A5A, 48'h5555_AAAA_5555,
                              '1, 6'd1));
        post_event(make_event(FUNC_UNKNOWN, 32'h1234_5678, '0, '1, 6'd2));
        post_event(make_event(twd_pkg::FUNC_READY, 32'hDEAD_BEEF, '1, '1, 6'd42));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'hFFFF_0000, 48'hAAAA_5555_AAAA,
                              '0, 6'd3));
        post_event(make_event(FUNC_UNKNOWN, '0, '0, '0, '0));
        settle();
    endtask

    task automatic test_capacity_extremes();
        cfg_write(11'd0);
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd1, 48'd1, '0, '0));
        post_event(make_event(twd_pkg::FUNC_READY, '0, '0, '0, 6'd17));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd2, 48'd2, '0, '0));
        settle();
        // above the store depth the usable size clamps
        cfg_write(11'd2047);
        repeat (4)
            post_event(make_event(twd_pkg::FUNC_TASK, $urandom(), 48'($urandom()),
                                  '0, '0));
        settle();
    endtask

    task automatic test_idle_overflow();
        while (idle_pool.size() < WORKER_DEPTH)
            post_event(make_event(twd_pkg::FUNC_READY, $urandom(), '0, '0,
                                  6'($urandom())));
        post_event(make_event(twd_pkg::FUNC_READY, '0, '0, '0, 6'd11));
        post_event(make_event(twd_pkg::FUNC_DONE, '0, 48'd100, 48'd350, 6'd12));
        post_event(make_event(FUNC_UNKNOWN, '1, '1, '1, '1));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd99, 48'd99, '0, '0));
        settle();
    endtask

    task automatic test_capacity_lowered();
        cfg_write(11'd1024);
        while (pending_tasks.size() < 12)
            post_event(make_event(twd_pkg::FUNC_TASK, $urandom(), 48'($urandom()),
                                  '0, '0));
        settle();
        // fill above the new capacity: queued tasks stay, arrivals drop
        cfg_write(11'd4);
        repeat (2)
            post_event(make_event(twd_pkg::FUNC_TASK, $urandom(), 48'($urandom()),
                                  '0, '0));
        while (pending_tasks.size() > 3)
            post_event(make_event(twd_pkg::FUNC_READY, '0, '0, '0, 6'($urandom())));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd500, 48'd500, '0, '0));
        post_event(make_event(twd_pkg::FUNC_TASK, 32'd501, 48'd501, '0, '0));
        settle();
    endtask

    task automatic test_backpressure();
        hold_req = PRESSURE_HOLD;
        calm     = 1'b1;
        repeat (24) post_event(random_event(40));
        calm = 1'b0;
        settle();
    endtask

    task automatic test_random_traffic();
        logic [10:0] caps [PHASES];
        int          phase;
        caps = '{11'd1, 11'd3, 11'd16, 11'd64, 11'd1024, 11'd2047, 11'd0, 11'd0};
        caps[6] = 11'($urandom_range(5, 200));
        caps[7] = 11'($urandom_range(0, 2047));
        for (phase = 0; phase < PHASES; phase++) begin
            cfg_write(caps[phase]);
            calm = (phase == 3);
            repeat (RANDOM_ITEMS / PHASES) post_event(random_event($urandom_range(25, 65)));
            calm = 1'b0;
            settle();
        end
    endtask

    initial begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_events();
        test_capacity_extremes();
        test_idle_overflow();
        test_capacity_lowered();
        test_backpressure();
        test_random_traffic();
        settle();
        $display("run: %0d events (directed, capacity changes, overflow, hold-off,",
                 events_sent);
        $display("random phases), %0d statuses checked, %0d drops, %0d workers lost",
                 results_checked, drops_seen, losses_seen);
        if (error_count == 0 && status_due.size() == 0)
            $display("task_worker_dispatcher verification clean");
        else
            $display("task_worker_dispatcher verification failed");
        $finish;
    end

endmodule

// ----- task_worker_dispatcher.f -----
design/twd_pkg.sv
design/twd_fifo.sv
design/twd_core.sv
design/task_worker_dispatcher.sv
dv/tb_top.sv
